[rtl/core/cubic_bezier_closest_point_top_assert.svh]
// assertion macros shared by the closest-point block
// used by cubic_bezier_closest_point_top; needs clk and rst in scope
`ifndef CUBIC_BEZIER_CLOSEST_POINT_TOP_ASSERT_SVH
`define CUBIC_BEZIER_CLOSEST_POINT_TOP_ASSERT_SVH

// same-cycle implication, checked outside reset
`define CBCP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define CBCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/cbcp_pkg.sv]
// shared types, constants and rounding helpers for the closest-point block
// no dependencies; used by cbcp_div, cbcp_mul and cubic_bezier_closest_point_top
`default_nettype none

package cbcp_pkg;

  // table sizing
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int TP_W = 7;
  localparam int CMP_W = CNT_W + TP_W;

  // divider sizing: dividend is index * 2^16 plus half the divisor
  localparam int DIV_W = IDX_W + 17;
  localparam int DIVC_W = $clog2(DIV_W + 1);

  // datapath widths
  localparam int MOP_W = 34;
  localparam int PROD_W = 2 * MOP_W;
  localparam int ACC_W = 54;
  localparam int W_W = 18;

  localparam logic [16:0] T_ONE = 17'd65536;

  // sequencer step limits
  localparam logic [4:0] EV_LAST = 5'd16;
  localparam logic [4:0] DS_LAST = 5'd3;

  // register map
  typedef enum logic [2:0] {
    REG_POINT0      = 3'd0,
    REG_POINT1      = 3'd1,
    REG_POINT2      = 3'd2,
    REG_POINT3      = 3'd3,
    REG_TABLE_POINTS = 3'd4,
    REG_STOP_WIDTH  = 3'd5
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_BUILD_DIV,
    ST_BUILD_EVAL,
    ST_BUILD_WR,
    ST_SCAN_RD,
    ST_SCAN_LD,
    ST_SCAN_DIST,
    ST_TL_DIV,
    ST_H_DIV,
    ST_CLAMP,
    ST_BIS_CHECK,
    ST_BIS_EVAL_A,
    ST_BIS_DIST_A,
    ST_BIS_EVAL_B,
    ST_BIS_DIST_B
  } state_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [CNT_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

  typedef struct packed {
    logic signed [MOP_W-1:0] a;
    logic signed [MOP_W-1:0] b;
  } mul_req_t;

  // floor((v + 2^15) / 2^16) for unsigned values
  function automatic logic [19:0] rnd16u(input logic [35:0] v);
    logic [35:0] s;
    s = v + 36'd32768;
    return s[35:16];
  endfunction

  // signed round to Q.8 followed by saturation to 32 bits
  function automatic logic signed [31:0] rnd_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-17:0] r;
    s = v + 54'sd32768;
    r = s[ACC_W-1:16];
    if (r > 38'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (r < -38'sd2147483648) begin
      return 32'sh80000000;
    end else begin
      return r[31:0];
    end
  endfunction

endpackage

`default_nettype wire

[rtl/core/cbcp_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`default_nettype none

module cbcp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/core/cbcp_div.sv]
// restoring divider, one quotient bit per cycle
// depends on cbcp_pkg for widths and request/response structs
`default_nettype none

module cbcp_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire cbcp_pkg::div_req_t req,
  output cbcp_pkg::div_rsp_t      rsp
);

  logic                           running;
  logic [cbcp_pkg::DIVC_W-1:0]    cnt;
  logic [cbcp_pkg::CNT_W-1:0]     rem;
  logic [cbcp_pkg::DIV_W-1:0]     quo;
  logic                           done;
  logic [cbcp_pkg::CNT_W:0]       shifted;
  logic                           ge;

  // trial subtract of the divisor
  always_comb begin
    shifted = {rem, quo[cbcp_pkg::DIV_W-1]};
    ge = shifted >= {1'b0, req.divisor};
  end

  // iteration control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        cnt <= cbcp_pkg::DIVC_W'(cbcp_pkg::DIV_W);
      end else if (running) begin
        cnt <= cnt - 1'b1;
        if (cnt == cbcp_pkg::DIVC_W'(1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // remainder and quotient shift
  always_ff @(posedge clk) begin
    if (req.start) begin
      quo <= req.dividend;
      rem <= '0;
    end else if (running) begin
      quo <= {quo[cbcp_pkg::DIV_W-2:0], ge};
      if (ge) begin
        rem <= cbcp_pkg::CNT_W'(shifted - {1'b0, req.divisor});
      end else begin
        rem <= shifted[cbcp_pkg::CNT_W-1:0];
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quotient = quo;

endmodule

`default_nettype wire

[rtl/core/cbcp_mul.sv]
// shared signed multiplier with registered product
// depends on cbcp_pkg for operand widths
`default_nettype none

module cbcp_mul (
  input  wire logic                                 clk,
  input  wire cbcp_pkg::mul_req_t                   req,
  output logic signed [cbcp_pkg::PROD_W-1:0]        prod
);

  // one product per cycle
  always_ff @(posedge clk) begin
    prod <= req.a * req.b;
  end

endmodule

`default_nettype wire

[rtl/core/cubic_bezier_closest_point_top.sv]
// closest-point search on a cubic bezier curve: sequencer and datapath
// depends on cbcp_pkg, cbcp_ram, cbcp_div, cbcp_mul and the assertion header
`default_nettype none

// Finds t (Q1.16) of the curve point nearest a query point. Pulse start while busy
// is low with query_x/query_y; one cycle with done high carries t_param, and the
// receiver cannot stall it. All multiplies go through one 34x34 multiplier and all
// divides through one bit-per-cycle divider. After a write to any of the six
// configuration registers the first query rebuilds the n-entry table: each entry
// takes one divide and one curve evaluation. Each query then scans the n entries,
// runs two divides for the bracket, and does bisection steps of two curve
// evaluations and two distances each, until the bracket is within stop_width.

module cubic_bezier_closest_point_top (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] query_x,
  input  wire logic signed [31:0] query_y,
  output logic                    done,
  output logic [16:0]             t_param,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [5:0]         paddr,
  input  wire logic [63:0]        pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);

  localparam int IW = cbcp_pkg::IDX_W;
  localparam int CW = cbcp_pkg::CNT_W;

  // configuration registers
  logic [63:0] point_xy [4];
  logic [6:0]  table_points;
  logic [16:0] stop_width;
  logic        table_ready;
  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  // sequencer
  cbcp_pkg::state_t state, state_next;
  logic [4:0]     step, step_next;
  logic [CW-1:0]  idx;

  // datapath registers
  logic signed [31:0] qx, qy, ex, ey;
  logic [16:0] tcur, t2, u2, tl, h, ta, tb;
  logic [cbcp_pkg::W_W-1:0] w0, w1, w2, w3;
  logic signed [cbcp_pkg::ACC_W-1:0] acc;
  logic [32:0] ax, ay;
  logic [63:0] sq;
  logic [64:0] dbest, da;
  logic [IW-1:0] best;

  // combinational helpers
  logic [CW-1:0] n_eff, nm1;
  logic [16:0] u, sw, mid;
  logic [17:0] sum_ab, tl_plus_h;
  logic more, in_eval, in_dist, idx_last;
  logic [35:0] p3;
  logic [19:0] rp, rp3;
  logic [64:0] dnew;
  logic signed [32:0] dx, dy;
  logic [IW-1:0] div_k;

  // unit interfaces
  cbcp_pkg::div_req_t div_req;
  cbcp_pkg::div_rsp_t div_rsp;
  cbcp_pkg::mul_req_t mul_req;
  logic signed [cbcp_pkg::PROD_W-1:0] prod;
  logic ram_we;
  logic [31:0] rdata_x, rdata_y;

  // register port decode
  assign cfg_wr = psel & penable & pwrite;
  assign cfg_idx = paddr[5:3];
  assign pready = 1'b1;

  always_comb begin
    case (cfg_idx)
      cbcp_pkg::REG_POINT0:       prdata = point_xy[0];
      cbcp_pkg::REG_POINT1:       prdata = point_xy[1];
      cbcp_pkg::REG_POINT2:       prdata = point_xy[2];
      cbcp_pkg::REG_POINT3:       prdata = point_xy[3];
      cbcp_pkg::REG_TABLE_POINTS: prdata = {57'd0, table_points};
      cbcp_pkg::REG_STOP_WIDTH:   prdata = {47'd0, stop_width};
      default:                    prdata = '0;
    endcase
  end

  // sample count clamped to between two and the table size
  always_comb begin
    if (table_points < 7'd2) begin
      n_eff = CW'(2);
    end else if ({{CW{1'b0}}, table_points} > cbcp_pkg::CMP_W'(cbcp_pkg::TABLE_DEPTH)) begin
      n_eff = CW'(cbcp_pkg::TABLE_DEPTH);
    end else begin
      n_eff = CW'(table_points);
    end
    nm1 = n_eff - 1'b1;
  end

  // arithmetic helpers
  always_comb begin
    u = cbcp_pkg::T_ONE - tcur;
    sw = (stop_width == 17'd0) ? 17'd1 : stop_width;
    sum_ab = {1'b0, ta} + {1'b0, tb};
    mid = sum_ab[17:1];
    more = (tb - ta) > sw;
    tl_plus_h = {1'b0, tl} + {1'b0, h};
    p3 = prod[35:0] + {prod[34:0], 1'b0};
    rp = cbcp_pkg::rnd16u(prod[35:0]);
    rp3 = cbcp_pkg::rnd16u(p3);
    dx = {qx[31], qx} - {ex[31], ex};
    dy = {qy[31], qy} - {ey[31], ey};
    dnew = {1'b0, sq} + {1'b0, prod[63:0]};
    in_eval = (state == cbcp_pkg::ST_BUILD_EVAL) || (state == cbcp_pkg::ST_BIS_EVAL_A) ||
              (state == cbcp_pkg::ST_BIS_EVAL_B);
    in_dist = (state == cbcp_pkg::ST_SCAN_DIST) || (state == cbcp_pkg::ST_BIS_DIST_A) ||
              (state == cbcp_pkg::ST_BIS_DIST_B);
    idx_last = (idx == nm1);
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      cbcp_pkg::ST_IDLE: begin
        if (start) begin
          state_next = table_ready ? cbcp_pkg::ST_SCAN_RD : cbcp_pkg::ST_BUILD_DIV;
        end
      end
      cbcp_pkg::ST_BUILD_DIV: begin
        if (div_rsp.done) state_next = cbcp_pkg::ST_BUILD_EVAL;
      end
      cbcp_pkg::ST_BUILD_EVAL: begin
        if (step == cbcp_pkg::EV_LAST) state_next = cbcp_pkg::ST_BUILD_WR;
      end
      cbcp_pkg::ST_BUILD_WR: begin
        state_next = idx_last ? cbcp_pkg::ST_SCAN_RD : cbcp_pkg::ST_BUILD_DIV;
      end
      cbcp_pkg::ST_SCAN_RD: state_next = cbcp_pkg::ST_SCAN_LD;
      cbcp_pkg::ST_SCAN_LD: state_next = cbcp_pkg::ST_SCAN_DIST;
      cbcp_pkg::ST_SCAN_DIST: begin
        if (step == cbcp_pkg::DS_LAST) begin
          state_next = idx_last ? cbcp_pkg::ST_TL_DIV : cbcp_pkg::ST_SCAN_RD;
        end
      end
      cbcp_pkg::ST_TL_DIV: begin
        if (div_rsp.done) state_next = cbcp_pkg::ST_H_DIV;
      end
      cbcp_pkg::ST_H_DIV: begin
        if (div_rsp.done) state_next = cbcp_pkg::ST_CLAMP;
      end
      cbcp_pkg::ST_CLAMP: state_next = cbcp_pkg::ST_BIS_CHECK;
      cbcp_pkg::ST_BIS_CHECK: begin
        state_next = more ? cbcp_pkg::ST_BIS_EVAL_A : cbcp_pkg::ST_IDLE;
      end
      cbcp_pkg::ST_BIS_EVAL_A: begin
        if (step == cbcp_pkg::EV_LAST) state_next = cbcp_pkg::ST_BIS_DIST_A;
      end
      cbcp_pkg::ST_BIS_DIST_A: begin
        if (step == cbcp_pkg::DS_LAST) state_next = cbcp_pkg::ST_BIS_EVAL_B;
      end
      cbcp_pkg::ST_BIS_EVAL_B: begin
        if (step == cbcp_pkg::EV_LAST) state_next = cbcp_pkg::ST_BIS_DIST_B;
      end
      cbcp_pkg::ST_BIS_DIST_B: begin
        if (step == cbcp_pkg::DS_LAST) state_next = cbcp_pkg::ST_BIS_CHECK;
      end
      default: state_next = cbcp_pkg::ST_IDLE;
    endcase
  end

  // step counter: restarts on each state change, parks at one while dividing
  always_comb begin
    if (state_next != state) begin
      step_next = '0;
    end else if ((state == cbcp_pkg::ST_BUILD_DIV) || (state == cbcp_pkg::ST_TL_DIV) ||
                 (state == cbcp_pkg::ST_H_DIV)) begin
      step_next = 5'd1;
    end else begin
      step_next = step + 1'b1;
    end
  end

  // unit controls: divider request, multiplier operands, table writes
  always_comb begin
    case (state)
      cbcp_pkg::ST_TL_DIV: div_k = best;
      cbcp_pkg::ST_H_DIV:  div_k = IW'(1);
      default:             div_k = idx[IW-1:0];
    endcase
    div_req.start = ((state == cbcp_pkg::ST_BUILD_DIV) || (state == cbcp_pkg::ST_TL_DIV) ||
                     (state == cbcp_pkg::ST_H_DIV)) && (step == 5'd0);
    div_req.dividend = cbcp_pkg::DIV_W'({div_k, 16'd0}) + cbcp_pkg::DIV_W'(nm1 >> 1);
    div_req.divisor = nm1;
    ram_we = (state == cbcp_pkg::ST_BUILD_WR);

    mul_req.a = '0;
    mul_req.b = '0;
    if (in_eval) begin
      case (step)
        5'd0: begin
          mul_req.a = $signed({17'd0, tcur});
          mul_req.b = $signed({17'd0, tcur});
        end
        5'd1: begin
          mul_req.a = $signed({17'd0, u});
          mul_req.b = $signed({17'd0, u});
        end
        5'd3: begin
          mul_req.a = $signed({17'd0, u2});
          mul_req.b = $signed({17'd0, u});
        end
        5'd4: begin
          mul_req.a = $signed({17'd0, u2});
          mul_req.b = $signed({17'd0, tcur});
        end
        5'd5: begin
          mul_req.a = $signed({17'd0, t2});
          mul_req.b = $signed({17'd0, u});
        end
        5'd6: begin
          mul_req.a = $signed({17'd0, t2});
          mul_req.b = $signed({17'd0, tcur});
        end
        5'd7: begin
          mul_req.a = $signed({{2{point_xy[0][31]}}, point_xy[0][31:0]});
          mul_req.b = $signed({16'd0, w0});
        end
        5'd8: begin
          mul_req.a = $signed({{2{point_xy[1][31]}}, point_xy[1][31:0]});
          mul_req.b = $signed({16'd0, w1});
        end
        5'd9: begin
          mul_req.a = $signed({{2{point_xy[2][31]}}, point_xy[2][31:0]});
          mul_req.b = $signed({16'd0, w2});
        end
        5'd10: begin
          mul_req.a = $signed({{2{point_xy[3][31]}}, point_xy[3][31:0]});
          mul_req.b = $signed({16'd0, w3});
        end
        5'd11: begin
          mul_req.a = $signed({{2{point_xy[0][63]}}, point_xy[0][63:32]});
          mul_req.b = $signed({16'd0, w0});
        end
        5'd12: begin
          mul_req.a = $signed({{2{point_xy[1][63]}}, point_xy[1][63:32]});
          mul_req.b = $signed({16'd0, w1});
        end
        5'd13: begin
          mul_req.a = $signed({{2{point_xy[2][63]}}, point_xy[2][63:32]});
          mul_req.b = $signed({16'd0, w2});
        end
        5'd14: begin
          mul_req.a = $signed({{2{point_xy[3][63]}}, point_xy[3][63:32]});
          mul_req.b = $signed({16'd0, w3});
        end
        default: begin
          mul_req.a = '0;
          mul_req.b = '0;
        end
      endcase
    end else if (in_dist) begin
      case (step)
        5'd1: begin
          mul_req.a = $signed({1'b0, ax});
          mul_req.b = $signed({1'b0, ax});
        end
        5'd2: begin
          mul_req.a = $signed({1'b0, ay});
          mul_req.b = $signed({1'b0, ay});
        end
        default: begin
          mul_req.a = '0;
          mul_req.b = '0;
        end
      endcase
    end
  end

  // control state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= cbcp_pkg::ST_IDLE;
      step <= '0;
      idx <= '0;
      done <= 1'b0;
      table_ready <= 1'b0;
      point_xy[0] <= '0;
      point_xy[1] <= '0;
      point_xy[2] <= '0;
      point_xy[3] <= '0;
      table_points <= 7'd64;
      stop_width <= 17'd16;
    end else begin
      state <= state_next;
      step <= step_next;
      done <= (state == cbcp_pkg::ST_BIS_CHECK) && !more;

      // register writes
      if (cfg_wr) begin
        case (cfg_idx)
          cbcp_pkg::REG_POINT0, cbcp_pkg::REG_POINT1, cbcp_pkg::REG_POINT2,
          cbcp_pkg::REG_POINT3: begin
            point_xy[cfg_idx[1:0]] <= pwdata;
            table_ready <= 1'b0;
          end
          cbcp_pkg::REG_TABLE_POINTS: begin
            table_points <= pwdata[6:0];
            table_ready <= 1'b0;
          end
          cbcp_pkg::REG_STOP_WIDTH: begin
            stop_width <= pwdata[16:0];
            table_ready <= 1'b0;
          end
          default: ;
        endcase
      end

      // table / scan index
      if ((state == cbcp_pkg::ST_IDLE) && start) begin
        idx <= '0;
      end else if (state == cbcp_pkg::ST_BUILD_WR) begin
        idx <= idx_last ? '0 : idx + 1'b1;
        if (idx_last) table_ready <= 1'b1;
      end else if ((state == cbcp_pkg::ST_SCAN_DIST) && (step == cbcp_pkg::DS_LAST)) begin
        idx <= idx + 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if ((state == cbcp_pkg::ST_IDLE) && start) begin
      qx <= query_x;
      qy <= query_y;
    end

    // curve evaluation
    if (in_eval) begin
      case (step)
        5'd1:  t2 <= rp[16:0];
        5'd2:  u2 <= rp[16:0];
        5'd4:  w0 <= rp[cbcp_pkg::W_W-1:0];
        5'd5:  w1 <= rp3[cbcp_pkg::W_W-1:0];
        5'd6:  w2 <= rp3[cbcp_pkg::W_W-1:0];
        5'd7:  w3 <= rp[cbcp_pkg::W_W-1:0];
        5'd8:  acc <= $signed(prod[cbcp_pkg::ACC_W-1:0]);
        5'd12: begin
          ex <= cbcp_pkg::rnd_sat(acc);
          acc <= $signed(prod[cbcp_pkg::ACC_W-1:0]);
        end
        5'd16: ey <= cbcp_pkg::rnd_sat(acc);
        default: acc <= acc + $signed(prod[cbcp_pkg::ACC_W-1:0]);
      endcase
    end

    // table entry load for the scan
    if (state == cbcp_pkg::ST_SCAN_LD) begin
      ex <= $signed(rdata_x);
      ey <= $signed(rdata_y);
    end

    // squared distance
    if (in_dist) begin
      if (step == 5'd0) begin
        ax <= dx[32] ? 33'(-dx) : dx;
        ay <= dy[32] ? 33'(-dy) : dy;
      end
      if (step == 5'd2) sq <= prod[63:0];
    end

    // scan minimum, first lowest index wins
    if ((state == cbcp_pkg::ST_SCAN_DIST) && (step == cbcp_pkg::DS_LAST)) begin
      if ((idx == '0) || (dnew < dbest)) begin
        dbest <= dnew;
        best <= idx[IW-1:0];
      end
    end

    // parameter selection
    if ((state == cbcp_pkg::ST_BUILD_DIV) && div_rsp.done) tcur <= div_rsp.quotient[16:0];
    if ((state == cbcp_pkg::ST_TL_DIV) && div_rsp.done) tl <= div_rsp.quotient[16:0];
    if ((state == cbcp_pkg::ST_H_DIV) && div_rsp.done) h <= div_rsp.quotient[16:0];

    // bracket around the coarse hit
    if (state == cbcp_pkg::ST_CLAMP) begin
      ta <= (tl > h) ? (tl - h) : 17'd0;
      tb <= (tl_plus_h > {1'b0, cbcp_pkg::T_ONE}) ? cbcp_pkg::T_ONE : tl_plus_h[16:0];
    end

    // bisection
    if (state == cbcp_pkg::ST_BIS_CHECK) begin
      if (more) begin
        tcur <= ta;
      end else begin
        t_param <= mid;
      end
    end
    if ((state == cbcp_pkg::ST_BIS_DIST_A) && (step == cbcp_pkg::DS_LAST)) begin
      da <= dnew;
      tcur <= tb;
    end
    if ((state == cbcp_pkg::ST_BIS_DIST_B) && (step == cbcp_pkg::DS_LAST)) begin
      if (da < dnew) begin
        tb <= mid;
      end else begin
        ta <= mid;
      end
    end
  end

  assign busy = (state != cbcp_pkg::ST_IDLE);

  // sample tables
  cbcp_ram #(.WIDTH(32), .DEPTH(cbcp_pkg::TABLE_DEPTH)) u_ram_x (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[IW-1:0]),
    .wdata (ex),
    .raddr (idx[IW-1:0]),
    .rdata (rdata_x)
  );

  cbcp_ram #(.WIDTH(32), .DEPTH(cbcp_pkg::TABLE_DEPTH)) u_ram_y (
    .clk   (clk),
    .we    (ram_we),
    .waddr (idx[IW-1:0]),
    .wdata (ey),
    .raddr (idx[IW-1:0]),
    .rdata (rdata_y)
  );

  // shared arithmetic units
  cbcp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .rsp (div_rsp)
  );

  cbcp_mul u_mul (
    .clk  (clk),
    .req  (mul_req),
    .prod (prod)
  );

  // checks
  `include "cubic_bezier_closest_point_top_assert.svh"

  `CBCP_ASSERT_NEXT(a_start_sets_busy, start && !busy, busy, "accepted word did not raise busy")
  `CBCP_ASSERT_NOW(a_done_after_check, done, $past(state) == cbcp_pkg::ST_BIS_CHECK, "done without finished bisection")
  `CBCP_ASSERT_NOW(a_t_in_range, done, t_param <= cbcp_pkg::T_ONE, "t_param above one")
  `CBCP_ASSERT_NOW(a_bracket_ordered, state == cbcp_pkg::ST_BIS_CHECK, (ta <= tb) && (tb <= cbcp_pkg::T_ONE), "bisection bracket out of order")

endmodule

`default_nettype wire

[dv/tb_cubic_bezier_closest_point_top.sv]
// testbench for the cubic bezier closest-point block: config writes, queries, t checks
// depends on cbcp_pkg and cubic_bezier_closest_point_top
`timescale 1ns / 100ps

module tb_cubic_bezier_closest_point_top;

  localparam longint CYCLE_LIMIT = 20000000;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic signed [31:0] query_x;
  logic signed [31:0] query_y;
  logic               done;
  logic [16:0]        t_param;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [5:0]         paddr;
  logic [63:0]        pwdata;
  logic [63:0]        prdata;
  logic               pready;

  cubic_bezier_closest_point_top uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .query_x(query_x), .query_y(query_y), .done(done), .t_param(t_param),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // shadow of the configuration and the sampled curve
  logic [63:0] ctrl_pt [4];
  logic [6:0]  samples_cfg;
  logic [16:0] stop_cfg;
  longint      curve_x [64];
  longint      curve_y [64];
  bit          curve_valid;

  logic [16:0] t_expected [$];
  int          errors;
  int          idle_pct;
  longint      cycles;

  // clock
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic longint sext(input logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  // curve point at parameter t, q23.8 with rounding and saturation
  function automatic void curve_at(input longint t, output longint x, output longint y);
    longint u, t2, u2, w0, w1, w2, w3, sx, sy;
    u  = 65536 - t;
    t2 = (t * t + 32768) >> 16;
    u2 = (u * u + 32768) >> 16;
    w0 = (u2 * u + 32768) >> 16;
    w1 = (3 * u2 * t + 32768) >> 16;
    w2 = (3 * t2 * u + 32768) >> 16;
    w3 = (t2 * t + 32768) >> 16;
    sx = sext(ctrl_pt[0][31:0]) * w0 + sext(ctrl_pt[1][31:0]) * w1
       + sext(ctrl_pt[2][31:0]) * w2 + sext(ctrl_pt[3][31:0]) * w3;
    sy = sext(ctrl_pt[0][63:32]) * w0 + sext(ctrl_pt[1][63:32]) * w1
       + sext(ctrl_pt[2][63:32]) * w2 + sext(ctrl_pt[3][63:32]) * w3;
    x = (sx + 32768) >>> 16;
    y = (sy + 32768) >>> 16;
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    if (y > 64'sd2147483647) y = 64'sd2147483647;
    if (y < -64'sd2147483648) y = -64'sd2147483648;
  endfunction

  // exact squared distance, 65 bits
  function automatic logic [64:0] dist_sq(input longint qx, qy, px, py);
    longint dx, dy;
    logic [63:0] ax, ay;
    logic [64:0] sx, sy;
    dx = qx - px;
    dy = qy - py;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    sx = ax * ax;
    sy = ay * ay;
    return sx + sy;
  endfunction

  function automatic longint sample_count();
    longint n;
    n = samples_cfg;
    if (n < 2) n = 2;
    if (n > 64) n = 64;
    return n;
  endfunction

  function automatic longint sample_t(input longint i, input longint n);
    return (i * 65536 + (n - 1) / 2) / (n - 1);
  endfunction

  // nearest-point parameter for one query; rebuilds the curve table when stale
  function automatic logic [16:0] nearest_t(input longint qx, input longint qy);
    longint n, best, tl, h, ta, tb, sw, mid, ax, ay, bx, by;
    logic [64:0] bd, d;
    n = sample_count();
    if (!curve_valid) begin
      for (int i = 0; i < n; i++) curve_at(sample_t(i, n), curve_x[i], curve_y[i]);
      curve_valid = 1'b1;
    end
    best = 0;
    bd = dist_sq(qx, qy, curve_x[0], curve_y[0]);
    for (int i = 1; i < n; i++) begin
      d = dist_sq(qx, qy, curve_x[i], curve_y[i]);
      if (d < bd) begin
        bd = d;
        best = i;
      end
    end
    tl = sample_t(best, n);
    h  = (65536 + (n - 1) / 2) / (n - 1);
    ta = (tl > h) ? tl - h : 0;
    tb = (tl + h > 65536) ? 65536 : tl + h;
    sw = (stop_cfg != 0) ? stop_cfg : 1;
    while (tb - ta > sw) begin
      mid = (ta + tb) >> 1;
      curve_at(ta, ax, ay);
      curve_at(tb, bx, by);
      if (dist_sq(qx, qy, ax, ay) < dist_sq(qx, qy, bx, by)) tb = mid;
      else ta = mid;
    end
    return 17'((ta + tb) >> 1);
  endfunction

  // result check: every done word against the oldest expectation
  always @(posedge clk) begin
    if (!rst && done) begin
      if (t_expected.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %0d", $time, t_param);
        errors++;
      end else begin
        if (t_param !== t_expected[0]) begin
          $display("%0t: t_param mismatch, expected %0d, got %0d",
                   $time, t_expected[0], t_param);
          errors++;
        end
        void'(t_expected.pop_front());
      end
    end
  end

  // one query word; start stays high unless the sender idles afterwards
  task automatic send_query(input logic [31:0] qx, input logic [31:0] qy);
    int gap;
    start   <= 1'b1;
    query_x <= qx;
    query_y <= qy;
    do @(posedge clk); while (busy);
    t_expected.push_back(nearest_t(sext(qx), sext(qy)));
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 1200) : $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop start and wait for every result and for the block to go idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (t_expected.size() != 0) @(posedge clk);
    while (busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // apb write: setup cycle, access cycle, then idle with psel low
  task automatic reg_write(input logic [2:0] idx, input logic [63:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      cbcp_pkg::REG_POINT0:       begin ctrl_pt[0] = val; curve_valid = 1'b0; end
      cbcp_pkg::REG_POINT1:       begin ctrl_pt[1] = val; curve_valid = 1'b0; end
      cbcp_pkg::REG_POINT2:       begin ctrl_pt[2] = val; curve_valid = 1'b0; end
      cbcp_pkg::REG_POINT3:       begin ctrl_pt[3] = val; curve_valid = 1'b0; end
      cbcp_pkg::REG_TABLE_POINTS: begin samples_cfg = val[6:0]; curve_valid = 1'b0; end
      cbcp_pkg::REG_STOP_WIDTH:   begin stop_cfg = val[16:0]; curve_valid = 1'b0; end
      default: ;
    endcase
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 4))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 131072)) - 65536);
      2: return 32'(int'($urandom_range(0, 8388608)) - 4194304);
      3: return ($urandom_range(0, 1) != 0) ? 32'h7FFFFFFF : 32'h80000000;
      default: return 32'(int'($urandom_range(0, 2097152)) - 1048576);
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] v;
    drain();
    for (int k = 0; k < 4; k++) begin
      v = {rand_coord(), rand_coord()};
      if ($urandom_range(0, 5) == 0) v = {$urandom, $urandom};
      reg_write(3'(k), v);
    end
    reg_write(cbcp_pkg::REG_TABLE_POINTS, ($urandom_range(0, 5) == 0) ?
              64'($urandom_range(0, 127)) : 64'($urandom_range(2, 12)));
    reg_write(cbcp_pkg::REG_STOP_WIDTH, ($urandom_range(0, 5) == 0) ?
              64'($urandom_range(0, 131071)) : 64'($urandom_range(1, 4096)));
  endtask

  // query near the curve most of the time, anywhere otherwise
  task automatic random_query();
    longint px, py;
    if ($urandom_range(0, 9) < 7) begin
      curve_at($urandom_range(0, 65536), px, py);
      send_query(32'(px + int'($urandom_range(0, 2048)) - 1024),
                 32'(py + int'($urandom_range(0, 2048)) - 1024));
    end else begin
      send_query($urandom, $urandom);
    end
  endtask

  // reset values: degenerate curve, every scan and bisection step ties
  task automatic test_reset_defaults();
    send_query(32'h0, 32'h0);
    send_query(32'h7FFFFFFF, 32'h80000000);
    send_query(32'h80000000, 32'h7FFFFFFF);
    drain();
  endtask

  // extremes of points and fields, clamped counts, stop widths, unused index
  task automatic test_directed();
    reg_write(cbcp_pkg::REG_POINT0, {32'h80000000, 32'h80000000});
    reg_write(cbcp_pkg::REG_POINT1, {32'h7FFFFFFF, 32'h7FFFFFFF});
    reg_write(cbcp_pkg::REG_POINT2, {32'h7FFFFFFF, 32'h7FFFFFFF});
    reg_write(cbcp_pkg::REG_POINT3, {32'h80000000, 32'h7FFFFFFF});
    reg_write(cbcp_pkg::REG_TABLE_POINTS, 64'd0);
    reg_write(cbcp_pkg::REG_STOP_WIDTH, 64'd0);
    send_query(32'h0, 32'h0);
    send_query(32'h7FFFFFFF, 32'h7FFFFFFF);
    send_query(32'h80000000, 32'h80000000);
    drain();
    reg_write(cbcp_pkg::REG_TABLE_POINTS, 64'd127);
    reg_write(cbcp_pkg::REG_STOP_WIDTH, 64'd65536);
    send_query(32'h0, 32'h7FFFFFFF);
    send_query(32'hFFFFFFFF, 32'h1);
    drain();
    reg_write(cbcp_pkg::REG_STOP_WIDTH, 64'd131071);
    send_query(32'h12345678, 32'hEDCBA987);
    drain();
    reg_write(cbcp_pkg::REG_POINT0, {32'hFFFF0000, 32'h00000000});
    reg_write(cbcp_pkg::REG_POINT1, {32'h00010000, 32'h00004000});
    reg_write(cbcp_pkg::REG_POINT2, {32'hFFFF0000, 32'h0000C000});
    reg_write(cbcp_pkg::REG_POINT3, {32'h00010000, 32'h00010000});
    reg_write(cbcp_pkg::REG_TABLE_POINTS, 64'd1);
    reg_write(cbcp_pkg::REG_STOP_WIDTH, 64'd1);
    send_query(32'h00008000, 32'h0);
    send_query(32'h0, 32'h00008000);
    drain();
    reg_write(cbcp_pkg::REG_TABLE_POINTS, 64'd64);
    send_query(32'h00004000, 32'h00002000);
    send_query(32'h00100000, 32'hFFF00000);
    drain();
    // unused indexes leave the table intact
    reg_write(3'd6, 64'hFFFFFFFFFFFFFFFF);
    reg_write(3'd7, 64'h0);
    send_query(32'h00002000, 32'h00009000);
    drain();
    reg_write(cbcp_pkg::REG_TABLE_POINTS, 64'd2);
    reg_write(cbcp_pkg::REG_STOP_WIDTH, 64'd16);
    send_query(32'h0000C000, 32'h00004000);
    send_query(32'h55555555, 32'hAAAAAAAA);
    drain();
  endtask

  // random queries under one sender idling pattern
  task automatic test_random_phase(input int pct, input int count);
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      if (i % 60 == 0) random_config();
      else if ($urandom_range(0, 99) == 0) drain();
      random_query();
    end
    drain();
  endtask

  initial begin
    errors      = 0;
    cycles      = 0;
    idle_pct    = 0;
    ctrl_pt     = '{default: 64'h0};
    samples_cfg = 7'd64;
    stop_cfg    = 17'd16;
    curve_valid = 1'b0;
    rst     <= 1'b1;
    start   <= 1'b0;
    query_x <= '0;
    query_y <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_directed();
    test_random_phase(0, 470);
    test_random_phase(61, 470);
    test_random_phase(0, 470);
    test_random_phase(15, 470);

    drain();
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
